// ===== rtl/core/mrrs_pkg.sv =====
package mrrs_pkg;

   localparam int MAX_CORES = 8;
   localparam int MAX_PROCS = 64;
   localparam int CORE_W    = $clog2(MAX_CORES);
   localparam int PROC_W    = $clog2(MAX_PROCS);
   localparam int CCNT_W    = $clog2(MAX_CORES + 1);
   localparam int QCNT_W    = $clog2(MAX_PROCS + 1);

   // input op codes (carried in tuser)
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // result kinds (carried in tuser)
   localparam logic KIND_RELEASE  = 1'b0;
   localparam logic KIND_DISPATCH = 1'b1;

   // register indexes
   localparam logic CSR_CORE_COUNT = 1'b0;
   localparam logic CSR_QUANTUM    = 1'b1;

   // one process table entry
   typedef struct packed {
      logic [15:0] remaining;
      logic [31:0] deadline;
      logic [31:0] arrival;
   } proc_entry_type;

   // ready queue control from the sequencer
   typedef struct packed {
      logic              push;
      logic [PROC_W-1:0] push_slot;
      logic              rd;
      logic              pop;
   } queue_ctl_type;

   // one result event
   typedef struct packed {
      logic              kind;
      logic [PROC_W-1:0] proc_slot;
      logic [CORE_W-1:0] core_id;
      logic              finished;
      logic              deadline_missed;
      logic [31:0]       finish_time;
      logic [31:0]       turnaround;
      logic [31:0]       context_changes;
      logic [15:0]       missed_total;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REL_RD,
      ST_REL_EVT,
      ST_DISP_CHK,
      ST_DISP_RD,
      ST_DISP_EVT,
      ST_FIN
   } state_type;

endpackage

// ===== rtl/core/mrrs_proc_table.sv =====
module mrrs_proc_table (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [mrrs_pkg::PROC_W-1:0]     wr_addr,
   input  mrrs_pkg::proc_entry_type        wr_data,
   input  logic                            rd_en,
   input  logic [mrrs_pkg::PROC_W-1:0]     rd_addr,
   output mrrs_pkg::proc_entry_type        rd_data_ff
);
   import mrrs_pkg::*;

   proc_entry_type mem [MAX_PROCS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/mrrs_ready_queue.sv =====
module mrrs_ready_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  mrrs_pkg::queue_ctl_type      ctl,
   output logic [mrrs_pkg::QCNT_W-1:0]  count,
   output logic [mrrs_pkg::PROC_W-1:0]  head_slot_ff
);
   import mrrs_pkg::*;

   logic [PROC_W-1:0] mem [MAX_PROCS];
   logic [PROC_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_ok;
   logic [PROC_W-1:0] tail;

   assign count   = count_ff;
   assign push_ok = ctl.push && (count_ff < QCNT_W'(MAX_PROCS));
   assign tail    = head_ff + count_ff[PROC_W-1:0];

   // pointer update; a push that finds the queue full is dropped
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_in + 1'b1;
      end
      if (ctl.pop && count_ff != '0) begin
         head_in  = head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[tail] <= ctl.push_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         head_slot_ff <= mem[head_ff];
      end
   end

endmodule

// ===== rtl/core/multicore_round_robin_scheduler.sv =====
// Round-robin scheduler for up to eight cores. Arrival transactions (tuser 0)
// load a process slot and append it to the ready queue; they produce no
// result and leave the scheduler idle. A tick transaction (tuser 1) emits
// release events (finish time earlier than now, in finish order, lower core
// on ties), then dispatch events, then advances time; tlast marks its final
// result, and a tick with nothing to do yields none. A tick is accepted, then
// scans the eight core slots before each release and once more to close the
// release phase, reads and writes the process table for each release and
// each dispatch, and closes. Output back-pressure can stall it. Config writes
// are taken every cycle.
module multicore_round_robin_scheduler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // process_id[5:0], burst_time[21:6], deadline[53:22], arrival_time[85:54]
   input  logic [87:0]  req_tdata,
   // op[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // proc_slot[5:0], core_id[8:6], finished[9], deadline_missed[10],
   // finish_time[42:11], turnaround[74:43], context_changes[106:75],
   // missed_total[122:107]
   output logic [127:0] rsp_tdata,
   // kind[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [7:0]   csr_data
);
   import mrrs_pkg::*;

   state_type         state_ff, state_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       ctx_ff, ctx_in;
   logic [15:0]       missed_ff, missed_in;
   logic [3:0]        core_count_ff, core_count_in;
   logic [7:0]        quantum_ff, quantum_in;

   logic [CORE_W-1:0] scan_idx_ff, scan_idx_in;
   logic              found_ff, found_in;
   logic [CORE_W-1:0] best_core_ff, best_core_in;
   logic [PROC_W-1:0] best_proc_ff, best_proc_in;
   logic [31:0]       best_fin_ff, best_fin_in;
   logic [CORE_W-1:0] disp_core_ff, disp_core_in;

   logic [MAX_CORES-1:0] core_busy_ff, core_busy_in;
   logic [PROC_W-1:0]    core_proc_ff [MAX_CORES];
   logic [PROC_W-1:0]    core_proc_in [MAX_CORES];
   logic [31:0]          core_fin_ff [MAX_CORES];
   logic [31:0]          core_fin_in [MAX_CORES];
   logic [CCNT_W-1:0]    busy_cnt_ff, busy_cnt_in;

   logic [CORE_W-1:0]    free_fifo_ff [MAX_CORES];
   logic [CORE_W-1:0]    free_fifo_in [MAX_CORES];
   logic [CORE_W-1:0]    free_head_ff, free_head_in;
   logic [CCNT_W-1:0]    free_cnt_ff, free_cnt_in;

   logic                 pend_vld_ff, pend_vld_in;
   rsp_item_type         pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic                 rsp_last_ff, rsp_last_in;

   queue_ctl_type        q_ctl;
   logic [QCNT_W-1:0]    q_count;
   logic [PROC_W-1:0]    q_head_slot;

   logic                 tbl_wr;
   logic [PROC_W-1:0]    tbl_wr_addr;
   proc_entry_type       tbl_wr_data;
   logic                 tbl_rd;
   logic [PROC_W-1:0]    tbl_rd_addr;
   proc_entry_type       tbl_rd_data;

   logic                 new_vld;
   rsp_item_type         new_item;
   logic                 flush;
   logic                 out_free;
   logic                 can_emit;
   logic                 cand;
   logic [CCNT_W-1:0]    limit;
   logic [15:0]          slice;
   logic                 miss;

   mrrs_proc_table u_table (
      .clock      (clock),
      .wr_en      (tbl_wr),
      .wr_addr    (tbl_wr_addr),
      .wr_data    (tbl_wr_data),
      .rd_en      (tbl_rd),
      .rd_addr    (tbl_rd_addr),
      .rd_data_ff (tbl_rd_data)
   );

   mrrs_ready_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .ctl          (q_ctl),
      .count        (q_count),
      .head_slot_ff (q_head_slot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_item_ff.missed_total, rsp_item_ff.context_changes,
                        rsp_item_ff.turnaround, rsp_item_ff.finish_time,
                        rsp_item_ff.deadline_missed, rsp_item_ff.finished,
                        rsp_item_ff.core_id, rsp_item_ff.proc_slot};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign can_emit = !pend_vld_ff || out_free;
   assign limit    = (core_count_ff > 4'(MAX_CORES)) ? CCNT_W'(MAX_CORES)
                                                     : CCNT_W'(core_count_ff);
   assign cand     = core_busy_ff[scan_idx_ff] && (core_fin_ff[scan_idx_ff] < now_ff) &&
                     (!found_ff || core_fin_ff[scan_idx_ff] < best_fin_ff);
   assign slice    = (tbl_rd_data.remaining < {8'b0, quantum_ff}) ? tbl_rd_data.remaining
                                                                 : {8'b0, quantum_ff};
   assign miss     = best_fin_ff > tbl_rd_data.deadline;

   // sequencer: next state, bookkeeping and event generation
   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      ctx_in        = ctx_ff;
      missed_in     = missed_ff;
      core_count_in = core_count_ff;
      quantum_in    = quantum_ff;
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      best_core_in  = best_core_ff;
      best_proc_in  = best_proc_ff;
      best_fin_in   = best_fin_ff;
      disp_core_in  = disp_core_ff;
      core_busy_in  = core_busy_ff;
      core_proc_in  = core_proc_ff;
      core_fin_in   = core_fin_ff;
      busy_cnt_in   = busy_cnt_ff;
      free_fifo_in  = free_fifo_ff;
      free_head_in  = free_head_ff;
      free_cnt_in   = free_cnt_ff;
      q_ctl         = '0;
      tbl_wr        = 1'b0;
      tbl_wr_addr   = '0;
      tbl_wr_data   = '0;
      tbl_rd        = 1'b0;
      tbl_rd_addr   = '0;
      new_vld       = 1'b0;
      new_item      = '0;
      flush         = 1'b0;

      // config writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CORE_COUNT: core_count_in = csr_data[3:0];
            CSR_QUANTUM:    quantum_in    = csr_data;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_ARRIVAL) begin
                  tbl_wr                = 1'b1;
                  tbl_wr_addr           = req_tdata[5:0];
                  tbl_wr_data.remaining = req_tdata[21:6];
                  tbl_wr_data.deadline  = req_tdata[53:22];
                  tbl_wr_data.arrival   = req_tdata[85:54];
                  q_ctl.push            = 1'b1;
                  q_ctl.push_slot       = req_tdata[5:0];
               end else begin
                  scan_idx_in = '0;
                  found_in    = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         // one core slot per cycle, keep the earliest expired one
         ST_SCAN: begin
            if (cand) begin
               found_in     = 1'b1;
               best_core_in = scan_idx_ff;
               best_proc_in = core_proc_ff[scan_idx_ff];
               best_fin_in  = core_fin_ff[scan_idx_ff];
            end
            if (scan_idx_ff == CORE_W'(MAX_CORES - 1)) begin
               state_in = found_in ? ST_REL_RD : ST_DISP_CHK;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_REL_RD: begin
            tbl_rd                     = 1'b1;
            tbl_rd_addr                = best_proc_ff;
            core_busy_in[best_core_ff] = 1'b0;
            busy_cnt_in                = busy_cnt_ff - 1'b1;
            if (free_cnt_ff < CCNT_W'(MAX_CORES)) begin
               free_fifo_in[free_head_ff + free_cnt_ff[CORE_W-1:0]] = best_core_ff;
               free_cnt_in = free_cnt_ff + 1'b1;
            end
            state_in = ST_REL_EVT;
         end
         ST_REL_EVT: begin
            if (can_emit) begin
               new_vld              = 1'b1;
               new_item.kind        = KIND_RELEASE;
               new_item.proc_slot   = best_proc_ff;
               new_item.core_id     = best_core_ff;
               new_item.finish_time = best_fin_ff;
               if (tbl_rd_data.remaining != '0) begin
                  ctx_in          = ctx_ff + 1'b1;
                  q_ctl.push      = 1'b1;
                  q_ctl.push_slot = best_proc_ff;
               end else begin
                  new_item.finished        = 1'b1;
                  new_item.deadline_missed = miss;
                  new_item.turnaround      = best_fin_ff - tbl_rd_data.arrival;
                  if (miss && missed_ff != 16'hFFFF) begin
                     missed_in = missed_ff + 1'b1;
                  end
               end
               new_item.context_changes = ctx_in;
               new_item.missed_total    = missed_in;
               scan_idx_in = '0;
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_DISP_CHK: begin
            if (q_count != '0 && busy_cnt_ff < limit && free_cnt_ff != '0) begin
               q_ctl.rd = 1'b1;
               state_in = ST_DISP_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DISP_RD: begin
            tbl_rd       = 1'b1;
            tbl_rd_addr  = q_head_slot;
            q_ctl.pop    = 1'b1;
            disp_core_in = free_fifo_ff[free_head_ff];
            free_head_in = free_head_ff + 1'b1;
            free_cnt_in  = free_cnt_ff - 1'b1;
            state_in     = ST_DISP_EVT;
         end
         // slice = min(remaining, quantum), write back the reduced remainder
         ST_DISP_EVT: begin
            if (can_emit) begin
               tbl_wr                     = 1'b1;
               tbl_wr_addr                = q_head_slot;
               tbl_wr_data                = tbl_rd_data;
               tbl_wr_data.remaining      = tbl_rd_data.remaining - slice;
               core_busy_in[disp_core_ff] = 1'b1;
               core_proc_in[disp_core_ff] = q_head_slot;
               core_fin_in[disp_core_ff]  = now_ff + {16'b0, slice};
               busy_cnt_in                = busy_cnt_ff + 1'b1;
               new_vld                    = 1'b1;
               new_item.kind              = KIND_DISPATCH;
               new_item.proc_slot         = q_head_slot;
               new_item.core_id           = disp_core_ff;
               new_item.finish_time       = now_ff + {16'b0, slice};
               new_item.context_changes   = ctx_ff;
               new_item.missed_total      = missed_ff;
               state_in                   = ST_DISP_CHK;
            end
         end
         ST_FIN: begin
            if (!pend_vld_ff) begin
               now_in   = now_ff + 1'b1;
               state_in = ST_IDLE;
            end else if (out_free) begin
               flush    = 1'b1;
               now_in   = now_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // one event is held back so that the final one can carry tlast
   always_comb begin
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (new_vld) begin
         if (pend_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_in     = new_item;
         pend_vld_in = 1'b1;
      end
      if (flush) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = pend_ff;
         rsp_last_in  = 1'b1;
         pend_vld_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         ctx_ff        <= '0;
         missed_ff     <= '0;
         core_count_ff <= 4'd1;
         quantum_ff    <= 8'd10;
         core_busy_ff  <= '0;
         busy_cnt_ff   <= '0;
         free_head_ff  <= '0;
         free_cnt_ff   <= CCNT_W'(MAX_CORES);
         for (int i = 0; i < MAX_CORES; i++) begin
            free_fifo_ff[i] <= CORE_W'(i);
         end
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         ctx_ff        <= ctx_in;
         missed_ff     <= missed_in;
         core_count_ff <= core_count_in;
         quantum_ff    <= quantum_in;
         core_busy_ff  <= core_busy_in;
         busy_cnt_ff   <= busy_cnt_in;
         free_head_ff  <= free_head_in;
         free_cnt_ff   <= free_cnt_in;
         free_fifo_ff  <= free_fifo_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      found_ff     <= found_in;
      best_core_ff <= best_core_in;
      best_proc_ff <= best_proc_in;
      best_fin_ff  <= best_fin_in;
      disp_core_ff <= disp_core_in;
      core_proc_ff <= core_proc_in;
      core_fin_ff  <= core_fin_in;
      pend_ff      <= pend_in;
      rsp_item_ff  <= rsp_item_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      $countones(core_busy_ff) == int'(busy_cnt_ff))
      else $error("busy count out of step with busy flags");

   // the core taken off the free queue in ST_DISP_RD is marked busy in ST_DISP_EVT, which can stall on the output
   a_core_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_DISP_EVT |-> int'(busy_cnt_ff) + int'(free_cnt_ff) == MAX_CORES)
      else $error("cores lost between busy set and free queue");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_vld_ff)
      else $error("held event left behind after tick");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && state_in == ST_IDLE |=> now_ff == $past(now_ff) + 32'd1)
      else $error("time did not advance at end of tick");

endmodule
